// ===== rtl/fwss_pkg.sv =====
// ----------------------------------------------------------------------------
// fwss_pkg
// shared types and constants of the four wheel speed synchronizer
// ----------------------------------------------------------------------------
package fwss_pkg;

   localparam int WHEEL_COUNT = 4;
   localparam int SPEED_W     = 16;
   localparam int MAG_W       = SPEED_W + 1;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN             = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_CORRECTION   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ENABLE_MINIMUM   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET_TOLERANCE = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYNC_ENABLE      = 3'd4;

   localparam logic [15:0] GAIN_RESET             = 16'd614;
   localparam logic [14:0] MAX_CORRECTION_RESET   = 15'd128;
   localparam logic [14:0] ENABLE_MINIMUM_RESET   = 15'd160;
   localparam logic [15:0] TARGET_TOLERANCE_RESET = 16'd48;
   localparam logic        SYNC_ENABLE_RESET      = 1'b1;

   typedef logic signed [SPEED_W-1:0] speed_type;
   typedef logic signed [MAG_W-1:0]   norm_type;

   typedef struct packed {
      logic [15:0] gain;
      logic [14:0] max_correction;
      logic [14:0] enable_minimum;
      logic [15:0] target_tolerance;
      logic        sync_enable;
   } cfg_type;

endpackage

// ===== rtl/fwss_gate.sv =====
// ----------------------------------------------------------------------------
// fwss_gate
// decides whether corrections apply: enable, minimum magnitude and spread
// ----------------------------------------------------------------------------
module fwss_gate (
   input  fwss_pkg::cfg_type   cfg,
   input  fwss_pkg::speed_type tgt [fwss_pkg::WHEEL_COUNT],
   output logic                apply
);

   logic [fwss_pkg::MAG_W-1:0] mag [fwss_pkg::WHEEL_COUNT];
   logic [fwss_pkg::MAG_W-1:0] mag_min;
   logic [fwss_pkg::MAG_W-1:0] mag_max;
   logic [fwss_pkg::MAG_W-1:0] spread;
   logic                       slow;

   always_comb begin
      for (int i = 0; i < fwss_pkg::WHEEL_COUNT; i++) begin
         if (tgt[i][fwss_pkg::SPEED_W-1]) begin
            mag[i] = -{tgt[i][fwss_pkg::SPEED_W-1], tgt[i]};
         end else begin
            mag[i] = {1'b0, tgt[i]};
         end
      end
   end

   always_comb begin
      mag_min = mag[0];
      mag_max = mag[0];
      slow    = 1'b0;
      for (int i = 0; i < fwss_pkg::WHEEL_COUNT; i++) begin
         if (mag[i] < {2'b00, cfg.enable_minimum}) begin
            slow = 1'b1;
         end
         if (mag[i] < mag_min) begin
            mag_min = mag[i];
         end
         if (mag[i] > mag_max) begin
            mag_max = mag[i];
         end
      end
   end

   assign spread = mag_max - mag_min;
   assign apply  = cfg.sync_enable && !slow && (spread <= {1'b0, cfg.target_tolerance});

endmodule

// ===== rtl/fwss_mean.sv =====
// ----------------------------------------------------------------------------
// fwss_mean
// direction-normalised measured speeds and their floor mean
// ----------------------------------------------------------------------------
module fwss_mean (
   input  fwss_pkg::speed_type tgt  [fwss_pkg::WHEEL_COUNT],
   input  fwss_pkg::speed_type meas [fwss_pkg::WHEEL_COUNT],
   output fwss_pkg::norm_type  norm [fwss_pkg::WHEEL_COUNT],
   output fwss_pkg::norm_type  mean
);

   logic signed [fwss_pkg::MAG_W+1:0] sum;

   always_comb begin
      for (int i = 0; i < fwss_pkg::WHEEL_COUNT; i++) begin
         if (tgt[i][fwss_pkg::SPEED_W-1]) begin
            norm[i] = -{meas[i][fwss_pkg::SPEED_W-1], meas[i]};
         end else if (tgt[i] != '0) begin
            norm[i] = {meas[i][fwss_pkg::SPEED_W-1], meas[i]};
         end else begin
            norm[i] = '0;
         end
      end
   end

   always_comb begin
      sum = '0;
      for (int i = 0; i < fwss_pkg::WHEEL_COUNT; i++) begin
         sum = sum + {{2{norm[i][fwss_pkg::MAG_W-1]}}, norm[i]};
      end
   end

   // floor divide by four
   assign mean = sum[fwss_pkg::MAG_W+1:2];

endmodule

// ===== rtl/fwss_wheel.sv =====
// ----------------------------------------------------------------------------
// fwss_wheel
// proportional correction of one wheel, clamped and saturated
// ----------------------------------------------------------------------------
module fwss_wheel (
   input  fwss_pkg::cfg_type   cfg,
   input  fwss_pkg::speed_type tgt,
   input  fwss_pkg::norm_type  norm,
   input  fwss_pkg::norm_type  mean,
   output fwss_pkg::speed_type res
);

   logic signed [17:0] err;
   logic signed [34:0] prod;
   logic signed [22:0] corr_full;
   logic signed [22:0] lim;
   logic signed [17:0] corr;
   logic signed [17:0] sum;

   assign err       = {mean[16], mean} - {norm[16], norm};
   assign prod      = $signed({1'b0, cfg.gain}) * err;
   assign corr_full = prod[34:12];
   assign lim       = $signed({8'd0, cfg.max_correction});

   always_comb begin
      if (corr_full > lim) begin
         corr = lim[17:0];
      end else if (corr_full < -lim) begin
         corr = 18'(-lim);
      end else begin
         corr = corr_full[17:0];
      end
   end

   always_comb begin
      if (tgt[15]) begin
         sum = {{2{tgt[15]}}, tgt} - corr;
      end else if (tgt != '0) begin
         sum = {{2{tgt[15]}}, tgt} + corr;
      end else begin
         sum = {{2{tgt[15]}}, tgt};
      end
   end

   always_comb begin
      if (sum[17:15] == 3'b000 || sum[17:15] == 3'b111) begin
         res = sum[15:0];
      end else if (sum[17]) begin
         res = 16'sh8000;
      end else begin
         res = 16'sh7fff;
      end
   end

endmodule

// ===== rtl/four_wheel_speed_sync.sv =====
// ----------------------------------------------------------------------------
// four_wheel_speed_sync
// mean-coupled proportional speed synchronisation of four wheels
// ----------------------------------------------------------------------------
// Takes one beat of four signed Q12.4 wheel targets and four measured speeds
// per clock, unless stalled by rsp_ready, and returns one beat of corrected
// targets. A beat passes an input register and a result register, and one
// beat is accepted every cycle unless both hold beats and rsp_ready is low;
// the result register lets a new beat enter while a finished one waits for
// rsp_ready. Gate, mean and per-wheel multiply-clamp logic sit between them.
// The user must write registers through csr_write_enable, csr_index and csr_write_data
// only while the block is idle, which it does not enforce; an unknown index is ignored.
module four_wheel_speed_sync (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [15:0]                  req_base_target_0,
   input  logic signed [15:0]                  req_base_target_1,
   input  logic signed [15:0]                  req_base_target_2,
   input  logic signed [15:0]                  req_base_target_3,
   input  logic signed [15:0]                  req_measured_0,
   input  logic signed [15:0]                  req_measured_1,
   input  logic signed [15:0]                  req_measured_2,
   input  logic signed [15:0]                  req_measured_3,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [15:0]                  rsp_corrected_0,
   output logic signed [15:0]                  rsp_corrected_1,
   output logic signed [15:0]                  rsp_corrected_2,
   output logic signed [15:0]                  rsp_corrected_3,
   output logic                                rsp_sync_applied,
   input  logic                                csr_write_enable,
   input  logic [fwss_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [fwss_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   fwss_pkg::cfg_type   cfg_ff;
   fwss_pkg::cfg_type   cfg_in;

   logic                in_valid_ff;
   logic                in_valid_in;
   fwss_pkg::speed_type tgt_ff  [fwss_pkg::WHEEL_COUNT];
   fwss_pkg::speed_type meas_ff [fwss_pkg::WHEEL_COUNT];

   logic                out_valid_ff;
   logic                out_valid_in;
   fwss_pkg::speed_type res_ff  [fwss_pkg::WHEEL_COUNT];
   fwss_pkg::speed_type res_in  [fwss_pkg::WHEEL_COUNT];
   logic                applied_ff;

   fwss_pkg::norm_type  norm [fwss_pkg::WHEEL_COUNT];
   fwss_pkg::norm_type  mean;
   fwss_pkg::speed_type wheel_res [fwss_pkg::WHEEL_COUNT];
   logic                apply;
   logic                out_free;
   logic                in_take;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            fwss_pkg::CSR_GAIN: begin
               cfg_in.gain = csr_write_data;
            end
            fwss_pkg::CSR_MAX_CORRECTION: begin
               cfg_in.max_correction = csr_write_data[14:0];
            end
            fwss_pkg::CSR_ENABLE_MINIMUM: begin
               cfg_in.enable_minimum = csr_write_data[14:0];
            end
            fwss_pkg::CSR_TARGET_TOLERANCE: begin
               cfg_in.target_tolerance = csr_write_data;
            end
            fwss_pkg::CSR_SYNC_ENABLE: begin
               cfg_in.sync_enable = csr_write_data[0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain             <= fwss_pkg::GAIN_RESET;
         cfg_ff.max_correction   <= fwss_pkg::MAX_CORRECTION_RESET;
         cfg_ff.enable_minimum   <= fwss_pkg::ENABLE_MINIMUM_RESET;
         cfg_ff.target_tolerance <= fwss_pkg::TARGET_TOLERANCE_RESET;
         cfg_ff.sync_enable      <= fwss_pkg::SYNC_ENABLE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // handshake
   assign out_free     = !out_valid_ff || rsp_ready;
   assign req_ready    = !in_valid_ff || out_free;
   assign in_take      = req_valid && req_ready;
   assign in_valid_in  = in_take || (in_valid_ff && !out_free);
   assign out_valid_in = (in_valid_ff && out_free) || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (in_take) begin
         tgt_ff[0]  <= req_base_target_0;
         tgt_ff[1]  <= req_base_target_1;
         tgt_ff[2]  <= req_base_target_2;
         tgt_ff[3]  <= req_base_target_3;
         meas_ff[0] <= req_measured_0;
         meas_ff[1] <= req_measured_1;
         meas_ff[2] <= req_measured_2;
         meas_ff[3] <= req_measured_3;
      end
   end

   fwss_gate u_gate (
      .cfg   (cfg_ff),
      .tgt   (tgt_ff),
      .apply (apply)
   );

   fwss_mean u_mean (
      .tgt  (tgt_ff),
      .meas (meas_ff),
      .norm (norm),
      .mean (mean)
   );

   for (genvar g = 0; g < fwss_pkg::WHEEL_COUNT; g++) begin : g_wheel
      fwss_wheel u_wheel (
         .cfg  (cfg_ff),
         .tgt  (tgt_ff[g]),
         .norm (norm[g]),
         .mean (mean),
         .res  (wheel_res[g])
      );
   end

   always_comb begin
      for (int i = 0; i < fwss_pkg::WHEEL_COUNT; i++) begin
         res_in[i] = apply ? wheel_res[i] : tgt_ff[i];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (in_valid_ff && out_free) begin
         res_ff     <= res_in;
         applied_ff <= apply;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_corrected_0  = res_ff[0];
   assign rsp_corrected_1  = res_ff[1];
   assign rsp_corrected_2  = res_ff[2];
   assign rsp_corrected_3  = res_ff[3];
   assign rsp_sync_applied = applied_ff;

endmodule
